[hdl/usbep0_pkg.sv]
package usbep0_pkg;

	localparam int Ep0MaxPacket = 64;
	localparam int MpsBits = $clog2(Ep0MaxPacket);

	typedef enum logic [2:0] {
		OP_SETUP   = 3'd0,
		OP_TX_DONE = 3'd1,
		OP_RX_DONE = 3'd2,
		OP_RESET   = 3'd3,
		OP_SUSPEND = 3'd4,
		OP_WAKEUP  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		STG_REQUEST    = 3'd0,
		STG_DATA_IN    = 3'd1,
		STG_DATA_IN_ZLP = 3'd2,
		STG_DATA_OUT   = 3'd3,
		STG_STATUS_IN  = 3'd4,
		STG_STATUS_OUT = 3'd5
	} stage_t;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_SEND = 3'd1;
	localparam logic [2:0] ACT_ZLP = 3'd2;
	localparam logic [2:0] ACT_RECV = 3'd3;
	localparam logic [2:0] ACT_ZRECV = 3'd4;
	localparam logic [2:0] ACT_STALL = 3'd5;

	localparam logic [3:0] SRC_NONE = 4'd0;
	localparam logic [3:0] SRC_ZERO = 4'd1;
	localparam logic [3:0] SRC_HALT = 4'd2;
	localparam logic [3:0] SRC_DEV = 4'd3;
	localparam logic [3:0] SRC_CFG = 4'd4;
	localparam logic [3:0] SRC_STR = 4'd5;
	localparam logic [3:0] SRC_CBYTE = 4'd6;
	localparam logic [3:0] SRC_ALT = 4'd7;
	localparam logic [3:0] SRC_CLASS = 4'd8;

	localparam logic [1:0] DS_DEFAULT = 2'd0;
	localparam logic [1:0] DS_ADDRESSED = 2'd1;
	localparam logic [1:0] DS_CONFIGURED = 2'd2;

	localparam logic [1:0] HALT_NONE = 2'd0;
	localparam logic [1:0] HALT_SET = 2'd1;
	localparam logic [1:0] HALT_CLEAR = 2'd2;

	localparam logic [1:0] FL_NONE = 2'd0;
	localparam logic [1:0] FL_IN = 2'd1;
	localparam logic [1:0] FL_OUT = 2'd2;
	localparam logic [1:0] FL_BOTH = 2'd3;

	localparam logic [2:0] CE_NONE = 3'd0;
	localparam logic [2:0] CE_CONFIGURED = 3'd1;
	localparam logic [2:0] CE_RESET = 3'd2;
	localparam logic [2:0] CE_SUSPEND = 3'd3;
	localparam logic [2:0] CE_WAKEUP = 3'd4;

	localparam logic [7:0] REQ_GET_STATUS = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
	localparam logic [7:0] REQ_GET_DESC = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIG = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIG = 8'd9;
	localparam logic [7:0] REQ_GET_IFACE = 8'd10;
	localparam logic [7:0] REQ_SET_IFACE = 8'd11;

	localparam logic [4:0] RCP_DEVICE = 5'd0;
	localparam logic [4:0] RCP_IFACE = 5'd1;
	localparam logic [4:0] RCP_EP = 5'd2;

	localparam logic [1:0] TYP_STANDARD = 2'd0;
	localparam logic [1:0] TYP_CLASS = 2'd1;
	localparam logic [1:0] TYP_VENDOR = 2'd2;

	localparam logic [7:0] DESC_DEVICE = 8'd1;
	localparam logic [7:0] DESC_CONFIG = 8'd2;
	localparam logic [7:0] DESC_STRING = 8'd3;

	localparam logic CFG_DEV_LEN = 1'b0;
	localparam logic CFG_CFG_LEN = 1'b1;

endpackage

[hdl/usb_control_endpoint_engine.sv]
// Endpoint-0 control transfer engine: one event in, one result out per event.
// Pipeline: two register stages (input register, result register); an accepted event
// is held in the input register until the result register is free, then moves into it.
// Throughput: one event per cycle while out_stall is low; the decode is a single pass between the two registers.
// Reset (arst_n low): device state default, stage awaiting request, configuration,
// interface, alternate setting and pending setup zero; descriptor lengths 18 and 32.
module usb_control_endpoint_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_index,
	input  logic [15:0] request_length,
	input  logic        endpoint_halted,
	input  logic signed [16:0] external_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  ep0_action,
	output logic [15:0] transfer_length,
	output logic [3:0]  data_source,
	output logic [7:0]  data_byte,
	output logic [1:0]  halt_op,
	output logic [7:0]  halt_endpoint,
	output logic [1:0]  flush_ep,
	output logic        address_valid,
	output logic [6:0]  new_address,
	output logic [2:0]  class_event,
	output logic [1:0]  device_state
);

	// Configuration registers
	logic [7:0]  dev_len_q;
	logic [15:0] cfg_len_q;

	// Input stage
	logic        v_s1;
	logic [2:0]  op_s1;
	logic [7:0]  rtype_s1, code_s1;
	logic [15:0] value_s1, index_s1, wlen_s1;
	logic        halted_s1;
	logic [16:0] ext_s1;

	// Engine state
	logic [1:0]  dev_q;
	usbep0_pkg::stage_t stage_q;
	logic [7:0]  conf_q, alt_q;
	logic [15:0] iface_q;
	logic [7:0]  p_type_q, p_code_q;
	logic [15:0] p_value_q, p_index_q, p_wlen_q;

	// Stage 1 advances when the result register is free or drained this cycle
	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_len_q <= 8'd18;
			cfg_len_q <= 16'd32;
		end else if (cfg_we) begin
			if (cfg_index == usbep0_pkg::CFG_DEV_LEN) dev_len_q <= cfg_data[7:0];
			else cfg_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1 <= opcode;
			rtype_s1 <= request_type;
			code_s1 <= request_code;
			value_s1 <= request_value;
			index_s1 <= request_index;
			wlen_s1 <= request_length;
			halted_s1 <= endpoint_halted;
			ext_s1 <= external_length;
		end
	end

	// Single-pass decode
	logic [7:0]  rt, cd;
	logic [15:0] val, idx, wl;
	logic [4:0]  recip;
	logic        ext_ok, ok, do_decode;
	logic [15:0] len, clen;
	logic [3:0]  src;
	logic [7:0]  byt;
	logic [1:0]  dev_n;
	usbep0_pkg::stage_t stage_n;
	logic [7:0]  conf_n, alt_n;
	logic [15:0] iface_n;
	logic [2:0]  o_act;
	logic [15:0] o_len;
	logic [3:0]  o_src;
	logic [7:0]  o_byte;
	logic [1:0]  o_hop;
	logic [7:0]  o_hep;
	logic [1:0]  o_fl;
	logic        o_av;
	logic [6:0]  o_na;
	logic [2:0]  o_ce;
	logic        capture;

	always_comb begin
		dev_n = dev_q; stage_n = stage_q; conf_n = conf_q; alt_n = alt_q; iface_n = iface_q;
		o_act = usbep0_pkg::ACT_NONE; o_len = '0; o_src = usbep0_pkg::SRC_NONE;
		o_byte = '0; o_hop = usbep0_pkg::HALT_NONE; o_hep = '0;
		o_fl = usbep0_pkg::FL_NONE; o_av = 1'b0; o_na = '0;
		o_ce = usbep0_pkg::CE_NONE;
		do_decode = 1'b0; capture = 1'b0;
		ok = 1'b0; len = '0; src = usbep0_pkg::SRC_NONE; byt = '0; clen = '0;
		// Setup decodes the fresh packet; rx complete decodes the stored one
		if (op_s1 == usbep0_pkg::OP_SETUP) begin
			rt = rtype_s1; cd = code_s1; val = value_s1; idx = index_s1; wl = wlen_s1;
		end else begin
			rt = p_type_q; cd = p_code_q; val = p_value_q; idx = p_index_q; wl = p_wlen_q;
		end
		recip = rt[4:0];
		ext_ok = !ext_s1[16];

		unique case (op_s1)
			usbep0_pkg::OP_SETUP: begin
				capture = 1'b1;
				if (stage_q == usbep0_pkg::STG_DATA_IN || stage_q == usbep0_pkg::STG_DATA_IN_ZLP
						|| stage_q == usbep0_pkg::STG_STATUS_IN)
					o_fl = usbep0_pkg::FL_IN;
				else if (stage_q == usbep0_pkg::STG_DATA_OUT
						|| stage_q == usbep0_pkg::STG_STATUS_OUT)
					o_fl = usbep0_pkg::FL_OUT;
				stage_n = usbep0_pkg::STG_REQUEST;
				if (!rt[7] && wl != 16'd0) begin
					stage_n = usbep0_pkg::STG_DATA_OUT;
					o_act = usbep0_pkg::ACT_RECV;
					o_len = wl;
				end else begin
					do_decode = 1'b1;
				end
			end
			usbep0_pkg::OP_TX_DONE: begin
				if (stage_q == usbep0_pkg::STG_DATA_IN_ZLP) begin
					stage_n = usbep0_pkg::STG_DATA_IN; o_act = usbep0_pkg::ACT_ZLP;
				end else if (stage_q == usbep0_pkg::STG_DATA_IN) begin
					stage_n = usbep0_pkg::STG_STATUS_OUT; o_act = usbep0_pkg::ACT_ZRECV;
				end else begin
					stage_n = usbep0_pkg::STG_REQUEST;
				end
			end
			usbep0_pkg::OP_RX_DONE: begin
				if (stage_q == usbep0_pkg::STG_DATA_OUT) do_decode = 1'b1;
				else stage_n = usbep0_pkg::STG_REQUEST;
			end
			usbep0_pkg::OP_RESET: begin
				dev_n = usbep0_pkg::DS_DEFAULT;
				stage_n = usbep0_pkg::STG_REQUEST;
				conf_n = '0;
				o_fl = usbep0_pkg::FL_BOTH;
				o_ce = usbep0_pkg::CE_RESET;
			end
			usbep0_pkg::OP_SUSPEND: begin
				o_fl = usbep0_pkg::FL_BOTH;
				stage_n = usbep0_pkg::STG_REQUEST;
				if (dev_q == usbep0_pkg::DS_CONFIGURED) o_ce = usbep0_pkg::CE_SUSPEND;
			end
			usbep0_pkg::OP_WAKEUP: begin
				if (dev_q == usbep0_pkg::DS_CONFIGURED) o_ce = usbep0_pkg::CE_WAKEUP;
			end
			default: ;
		endcase

		if (do_decode) begin
			unique case (rt[6:5])
				usbep0_pkg::TYP_STANDARD: begin
					if (recip == usbep0_pkg::RCP_DEVICE) begin
						unique case (cd)
							usbep0_pkg::REQ_GET_STATUS: begin
								ok = 1'b1; len = 16'd2; src = usbep0_pkg::SRC_ZERO;
							end
							usbep0_pkg::REQ_SET_ADDRESS: begin
								o_av = 1'b1; o_na = val[6:0];
								if (dev_q == usbep0_pkg::DS_DEFAULT)
									dev_n = usbep0_pkg::DS_ADDRESSED;
								else if (dev_q == usbep0_pkg::DS_ADDRESSED && val == 16'd0)
									dev_n = usbep0_pkg::DS_DEFAULT;
								ok = 1'b1;
							end
							usbep0_pkg::REQ_GET_DESC: begin
								if (val[15:8] == usbep0_pkg::DESC_DEVICE) begin
									ok = 1'b1; len = {8'd0, dev_len_q}; src = usbep0_pkg::SRC_DEV;
								end else if (val[15:8] == usbep0_pkg::DESC_CONFIG) begin
									ok = 1'b1; len = cfg_len_q; src = usbep0_pkg::SRC_CFG;
								end else if (val[15:8] == usbep0_pkg::DESC_STRING && ext_ok) begin
									ok = 1'b1; len = ext_s1[15:0]; src = usbep0_pkg::SRC_STR;
								end
							end
							usbep0_pkg::REQ_GET_CONFIG: begin
								ok = 1'b1; len = 16'd1; src = usbep0_pkg::SRC_CBYTE; byt = conf_q;
							end
							usbep0_pkg::REQ_SET_CONFIG: begin
								if (dev_q == usbep0_pkg::DS_CONFIGURED) begin
									conf_n = '0; iface_n = '0; alt_n = '0;
									dev_n = usbep0_pkg::DS_ADDRESSED; o_ce = usbep0_pkg::CE_RESET;
								end else if (dev_q == usbep0_pkg::DS_ADDRESSED && val != 16'd0) begin
									conf_n = val[7:0]; iface_n = '0; alt_n = '0;
									dev_n = usbep0_pkg::DS_CONFIGURED;
									o_ce = usbep0_pkg::CE_CONFIGURED;
								end
								ok = 1'b1;
							end
							default: ;
						endcase
					end else if (recip == usbep0_pkg::RCP_IFACE) begin
						unique case (cd)
							usbep0_pkg::REQ_GET_STATUS: begin
								ok = 1'b1; len = 16'd2; src = usbep0_pkg::SRC_ZERO;
							end
							usbep0_pkg::REQ_SET_IFACE: begin
								iface_n = idx; alt_n = val[7:0]; ok = 1'b1;
							end
							usbep0_pkg::REQ_GET_IFACE: begin
								ok = 1'b1; len = 16'd1; src = usbep0_pkg::SRC_ALT; byt = alt_q;
							end
							default: ;
						endcase
					end else if (recip == usbep0_pkg::RCP_EP) begin
						unique case (cd)
							usbep0_pkg::REQ_GET_STATUS: begin
								ok = 1'b1; len = 16'd2; src = usbep0_pkg::SRC_HALT;
								byt = {7'd0, halted_s1};
							end
							usbep0_pkg::REQ_SET_FEATURE: begin
								if (val == 16'd0) begin
									o_hop = usbep0_pkg::HALT_SET; o_hep = idx[7:0]; ok = 1'b1;
								end
							end
							usbep0_pkg::REQ_CLEAR_FEATURE: begin
								if (val == 16'd0) begin
									o_hop = usbep0_pkg::HALT_CLEAR; o_hep = idx[7:0]; ok = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				usbep0_pkg::TYP_CLASS, usbep0_pkg::TYP_VENDOR: begin
					if (ext_ok) begin
						ok = 1'b1; len = ext_s1[15:0]; src = usbep0_pkg::SRC_CLASS;
					end
				end
				default: ;
			endcase

			clen = (len > wl) ? wl : len;
			if (!ok) begin
				// Refused: halt the named endpoint, else stall ep0
				if (recip == usbep0_pkg::RCP_EP) begin
					o_hop = usbep0_pkg::HALT_SET; o_hep = idx[7:0];
				end else begin
					o_act = usbep0_pkg::ACT_STALL;
				end
				stage_n = usbep0_pkg::STG_REQUEST;
			end else if (!rt[7]) begin
				stage_n = usbep0_pkg::STG_STATUS_IN; o_act = usbep0_pkg::ACT_ZLP;
			end else if (clen < wl && clen[usbep0_pkg::MpsBits-1:0] == '0) begin
				if (clen != 16'd0) begin
					stage_n = usbep0_pkg::STG_DATA_IN_ZLP; o_act = usbep0_pkg::ACT_SEND;
					o_len = clen; o_src = src; o_byte = byt;
				end else begin
					stage_n = usbep0_pkg::STG_DATA_IN; o_act = usbep0_pkg::ACT_ZLP;
				end
			end else if (clen != 16'd0) begin
				stage_n = usbep0_pkg::STG_DATA_IN; o_act = usbep0_pkg::ACT_SEND;
				o_len = clen; o_src = src; o_byte = byt;
			end else begin
				stage_n = usbep0_pkg::STG_STATUS_OUT; o_act = usbep0_pkg::ACT_ZLP;
			end
		end
	end

	logic fire;
	assign fire = v_s1 && adv;

	// Hold state; advance on each event that moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= usbep0_pkg::DS_DEFAULT;
			stage_q <= usbep0_pkg::STG_REQUEST;
			conf_q <= '0;
			alt_q <= '0;
			iface_q <= '0;
			p_type_q <= '0; p_code_q <= '0;
			p_value_q <= '0; p_index_q <= '0; p_wlen_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv) out_valid <= v_s1;
			if (fire) begin
				dev_q <= dev_n; stage_q <= stage_n; conf_q <= conf_n;
				alt_q <= alt_n; iface_q <= iface_n;
				if (capture) begin
					p_type_q <= rtype_s1; p_code_q <= code_s1;
					p_value_q <= value_s1; p_index_q <= index_s1; p_wlen_q <= wlen_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ep0_action <= o_act;
			transfer_length <= o_len;
			data_source <= o_src;
			data_byte <= o_byte;
			halt_op <= o_hop;
			halt_endpoint <= o_hep;
			flush_ep <= o_fl;
			address_valid <= o_av;
			new_address <= o_na;
			class_event <= o_ce;
			device_state <= dev_n;
		end
	end

endmodule

[sim/tb_usb_control_endpoint_engine.sv]
module tb_usb_control_endpoint_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles = 8;

	// one setup/event transaction as driven on the input side
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  rtype;
		logic [7:0]  code;
		logic [15:0] value;
		logic [15:0] index;
		logic [15:0] wlen;
		logic        halted;
		logic [16:0] ext;
	} event_t;

	// one ep0 reply as seen on the output side
	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] xfer_len;
		logic [3:0]  source;
		logic [7:0]  dbyte;
		logic [1:0]  hop;
		logic [7:0]  hep;
		logic [1:0]  flush;
		logic        addr_vld;
		logic [6:0]  addr;
		logic [2:0]  cev;
		logic [1:0]  dstate;
	} reply_t;

	// directed row: event, typed-in reply and whether that reply is checked as typed
	typedef struct {
		event_t ev;
		reply_t rep;
		bit     typed;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_index;
	logic [15:0] request_length;
	logic        endpoint_halted;
	logic signed [16:0] external_length;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  ep0_action;
	logic [15:0] transfer_length;
	logic [3:0]  data_source;
	logic [7:0]  data_byte;
	logic [1:0]  halt_op;
	logic [7:0]  halt_endpoint;
	logic [1:0]  flush_ep;
	logic        address_valid;
	logic [6:0]  new_address;
	logic [2:0]  class_event;
	logic [1:0]  device_state;

	usb_control_endpoint_engine uut (.*);

	// shadow copy of the engine state
	logic [7:0]  dev_len_reg;
	logic [15:0] cfg_len_reg;
	logic [1:0]  dev_st;
	usbep0_pkg::stage_t stage;
	logic [7:0]  cur_cfg;
	logic [15:0] cur_iface;
	logic [7:0]  cur_alt;
	logic [7:0]  p_rtype;
	logic [7:0]  p_code;
	logic [15:0] p_value;
	logic [15:0] p_index;
	logic [15:0] p_wlen;

	reply_t pending_replies[$];
	int     mismatches;
	int     idle_cycles;
	bit     idle_enabled;
	bit     timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic shadow_reset();
		dev_len_reg = 8'd18;
		cfg_len_reg = 16'd32;
		dev_st = usbep0_pkg::DS_DEFAULT;
		stage = usbep0_pkg::STG_REQUEST;
		cur_cfg = '0;
		cur_iface = '0;
		cur_alt = '0;
		{p_rtype, p_code, p_value, p_index, p_wlen} = '0;
	endtask

	// decode the held setup packet; updates state and fills r
	task automatic decode_setup(input event_t ev, inout reply_t r);
		logic [4:0]  recip;
		logic        ext_ok;
		logic        ok;
		logic [15:0] len;
		logic [3:0]  src;
		logic [7:0]  byt;
		recip = p_rtype[4:0];
		ext_ok = ~ev.ext[16];
		ok = 1'b0;
		len = '0;
		src = usbep0_pkg::SRC_NONE;
		byt = '0;
		case (p_rtype[6:5])
			usbep0_pkg::TYP_STANDARD: begin
				if (recip == usbep0_pkg::RCP_DEVICE) begin
					case (p_code)
						usbep0_pkg::REQ_GET_STATUS: begin
							ok = 1'b1; len = 16'd2; src = usbep0_pkg::SRC_ZERO;
						end
						usbep0_pkg::REQ_SET_ADDRESS: begin
							r.addr_vld = 1'b1;
							r.addr = p_value[6:0];
							if (dev_st == usbep0_pkg::DS_DEFAULT) dev_st = usbep0_pkg::DS_ADDRESSED;
							else if (dev_st == usbep0_pkg::DS_ADDRESSED && p_value == 16'd0)
								dev_st = usbep0_pkg::DS_DEFAULT;
							ok = 1'b1;
						end
						usbep0_pkg::REQ_GET_DESC: begin
							case (p_value[15:8])
								usbep0_pkg::DESC_DEVICE: begin
									ok = 1'b1; len = {8'd0, dev_len_reg}; src = usbep0_pkg::SRC_DEV;
								end
								usbep0_pkg::DESC_CONFIG: begin
									ok = 1'b1; len = cfg_len_reg; src = usbep0_pkg::SRC_CFG;
								end
								usbep0_pkg::DESC_STRING: if (ext_ok) begin
									ok = 1'b1; len = ev.ext[15:0]; src = usbep0_pkg::SRC_STR;
								end
								default: ;
							endcase
						end
						usbep0_pkg::REQ_GET_CONFIG: begin
							ok = 1'b1; len = 16'd1; src = usbep0_pkg::SRC_CBYTE; byt = cur_cfg;
						end
						usbep0_pkg::REQ_SET_CONFIG: begin
							if (dev_st == usbep0_pkg::DS_CONFIGURED) begin
								cur_cfg = '0; cur_iface = '0; cur_alt = '0;
								dev_st = usbep0_pkg::DS_ADDRESSED; r.cev = usbep0_pkg::CE_RESET;
							end else if (dev_st == usbep0_pkg::DS_ADDRESSED && p_value != 16'd0) begin
								cur_cfg = p_value[7:0]; cur_iface = '0; cur_alt = '0;
								dev_st = usbep0_pkg::DS_CONFIGURED; r.cev = usbep0_pkg::CE_CONFIGURED;
							end
							ok = 1'b1;
						end
						default: ;
					endcase
				end else if (recip == usbep0_pkg::RCP_IFACE) begin
					case (p_code)
						usbep0_pkg::REQ_GET_STATUS: begin
							ok = 1'b1; len = 16'd2; src = usbep0_pkg::SRC_ZERO;
						end
						usbep0_pkg::REQ_SET_IFACE: begin
							cur_iface = p_index; cur_alt = p_value[7:0]; ok = 1'b1;
						end
						usbep0_pkg::REQ_GET_IFACE: begin
							ok = 1'b1; len = 16'd1; src = usbep0_pkg::SRC_ALT; byt = cur_alt;
						end
						default: ;
					endcase
				end else if (recip == usbep0_pkg::RCP_EP) begin
					case (p_code)
						usbep0_pkg::REQ_GET_STATUS: begin
							ok = 1'b1; len = 16'd2; src = usbep0_pkg::SRC_HALT;
							byt = {7'd0, ev.halted};
						end
						usbep0_pkg::REQ_SET_FEATURE: if (p_value == 16'd0) begin
							r.hop = usbep0_pkg::HALT_SET; r.hep = p_index[7:0]; ok = 1'b1;
						end
						usbep0_pkg::REQ_CLEAR_FEATURE: if (p_value == 16'd0) begin
							r.hop = usbep0_pkg::HALT_CLEAR; r.hep = p_index[7:0]; ok = 1'b1;
						end
						default: ;
					endcase
				end
			end
			usbep0_pkg::TYP_CLASS, usbep0_pkg::TYP_VENDOR: if (ext_ok) begin
				ok = 1'b1; len = ev.ext[15:0]; src = usbep0_pkg::SRC_CLASS;
			end
			default: ;
		endcase

		// refuse: halt the endpoint, otherwise stall ep0
		if (!ok) begin
			if (recip == usbep0_pkg::RCP_EP) begin
				r.hop = usbep0_pkg::HALT_SET; r.hep = p_index[7:0];
			end else r.action = usbep0_pkg::ACT_STALL;
			stage = usbep0_pkg::STG_REQUEST;
			return;
		end
		if (len > p_wlen) len = p_wlen;
		if (!p_rtype[7]) begin
			stage = usbep0_pkg::STG_STATUS_IN;
			r.action = usbep0_pkg::ACT_ZLP;
			return;
		end
		if (len < p_wlen && len[usbep0_pkg::MpsBits-1:0] == '0) begin
			if (len != 16'd0) begin
				stage = usbep0_pkg::STG_DATA_IN_ZLP;
				r.action = usbep0_pkg::ACT_SEND; r.xfer_len = len; r.source = src; r.dbyte = byt;
			end else begin
				stage = usbep0_pkg::STG_DATA_IN;
				r.action = usbep0_pkg::ACT_ZLP;
			end
		end else if (len != 16'd0) begin
			stage = usbep0_pkg::STG_DATA_IN;
			r.action = usbep0_pkg::ACT_SEND; r.xfer_len = len; r.source = src; r.dbyte = byt;
		end else begin
			stage = usbep0_pkg::STG_STATUS_OUT;
			r.action = usbep0_pkg::ACT_ZLP;
		end
	endtask

	// predict the reply to one event and advance the shadow state
	task automatic predict_reply(input event_t ev, output reply_t r);
		r = '0;
		case (ev.op)
			usbep0_pkg::OP_SETUP: begin
				if (stage inside {usbep0_pkg::STG_DATA_IN, usbep0_pkg::STG_DATA_IN_ZLP,
						usbep0_pkg::STG_STATUS_IN})
					r.flush = usbep0_pkg::FL_IN;
				else if (stage inside {usbep0_pkg::STG_DATA_OUT, usbep0_pkg::STG_STATUS_OUT})
					r.flush = usbep0_pkg::FL_OUT;
				stage = usbep0_pkg::STG_REQUEST;
				{p_rtype, p_code, p_value, p_index, p_wlen} =
					{ev.rtype, ev.code, ev.value, ev.index, ev.wlen};
				if (!ev.rtype[7] && ev.wlen != 16'd0) begin
					stage = usbep0_pkg::STG_DATA_OUT;
					r.action = usbep0_pkg::ACT_RECV; r.xfer_len = ev.wlen;
				end else decode_setup(ev, r);
			end
			usbep0_pkg::OP_TX_DONE: begin
				if (stage == usbep0_pkg::STG_DATA_IN_ZLP) begin
					stage = usbep0_pkg::STG_DATA_IN; r.action = usbep0_pkg::ACT_ZLP;
				end else if (stage == usbep0_pkg::STG_DATA_IN) begin
					stage = usbep0_pkg::STG_STATUS_OUT; r.action = usbep0_pkg::ACT_ZRECV;
				end else stage = usbep0_pkg::STG_REQUEST;
			end
			usbep0_pkg::OP_RX_DONE: begin
				if (stage == usbep0_pkg::STG_DATA_OUT) decode_setup(ev, r);
				else stage = usbep0_pkg::STG_REQUEST;
			end
			usbep0_pkg::OP_RESET: begin
				dev_st = usbep0_pkg::DS_DEFAULT; stage = usbep0_pkg::STG_REQUEST; cur_cfg = '0;
				r.flush = usbep0_pkg::FL_BOTH; r.cev = usbep0_pkg::CE_RESET;
			end
			usbep0_pkg::OP_SUSPEND: begin
				r.flush = usbep0_pkg::FL_BOTH; stage = usbep0_pkg::STG_REQUEST;
				if (dev_st == usbep0_pkg::DS_CONFIGURED) r.cev = usbep0_pkg::CE_SUSPEND;
			end
			usbep0_pkg::OP_WAKEUP:
				if (dev_st == usbep0_pkg::DS_CONFIGURED) r.cev = usbep0_pkg::CE_WAKEUP;
			default: ;
		endcase
		r.dstate = dev_st;
	endtask

	function automatic event_t mk_event(logic [2:0] op, logic [7:0] rt, logic [7:0] cd,
			logic [15:0] v, logic [15:0] ix, logic [15:0] wl, logic h, logic [16:0] x);
		event_t e;
		e = '{op, rt, cd, v, ix, wl, h, x};
		return e;
	endfunction

	// random event: mostly setup requests, most of them shaped toward standard codes, with random content
	function automatic event_t random_event();
		event_t e;
		int pick;
		e.rtype = 8'($urandom);
		e.code = 8'($urandom);
		e.value = 16'($urandom);
		e.index = 16'($urandom);
		e.wlen = 16'($urandom);
		e.halted = 1'($urandom);
		e.ext = 17'($urandom);
		e.op = usbep0_pkg::OP_SETUP;
		pick = $urandom_range(0, 99);
		if (pick < 20) e.op = usbep0_pkg::OP_TX_DONE;
		else if (pick < 28) e.op = usbep0_pkg::OP_RX_DONE;
		else if (pick < 31) e.op = usbep0_pkg::OP_RESET;
		else if (pick < 34) e.op = usbep0_pkg::OP_SUSPEND;
		else if (pick < 37) e.op = usbep0_pkg::OP_WAKEUP;
		else if (pick < 39) e.op = 3'($urandom_range(6, 7));
		if (e.op == usbep0_pkg::OP_SETUP && $urandom_range(0, 9) < 8) begin
			e.rtype[6:5] = ($urandom_range(0, 9) < 7) ? usbep0_pkg::TYP_STANDARD : e.rtype[6:5];
			e.rtype[4:0] = 5'($urandom_range(0, 3));
			e.code = 8'($urandom_range(0, 12));
			if ($urandom_range(0, 1)) e.value[15:8] = 8'($urandom_range(0, 4));
			if ($urandom_range(0, 2) == 0) e.value = 16'($urandom_range(0, 2));
			if ($urandom_range(0, 2) != 0) e.wlen = 16'($urandom_range(0, 200));
			if ($urandom_range(0, 3) == 0) e.wlen = 16'(64 * $urandom_range(0, 3));
			if ($urandom_range(0, 1)) e.ext = 17'($urandom_range(0, 200));
			if ($urandom_range(0, 3) == 0) e.ext = 17'(64 * $urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0) e.ext = '1;
		end
		return e;
	endfunction

	// drive one event at the falling edge and hold it until accepted
	task automatic send_event(input event_t ev);
		int gap;
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		{opcode, request_type, request_code, request_value, request_index,
			request_length, endpoint_halted, external_length} <= ev;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// one write, then cfg_we low again before returning, so back-to-back writes never collide
	task automatic write_register(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == usbep0_pkg::CFG_DEV_LEN) dev_len_reg = val[7:0];
		else cfg_len_reg = val;
		@(negedge clk);
	endtask

	// drop valid and wait until every reply has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0 && !timed_out) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// predict on acceptance, compare on delivery
	always @(posedge clk) begin
		reply_t want;
		reply_t got;
		if (arst_n && in_valid && !in_stall) begin
			predict_reply({opcode, request_type, request_code, request_value, request_index,
				request_length, endpoint_halted, external_length}, want);
			pending_replies.push_back(want);
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{ep0_action, transfer_length, data_source, data_byte, halt_op,
				halt_endpoint, flush_ep, address_valid, new_address, class_event,
				device_state};
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected reply %h", got);
			end else begin
				want = pending_replies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("reply mismatch: expected %h actual %h",
						want, got);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			timed_out = 1'b1;
			$display("usb_control_endpoint_engine: mismatch");
			$finish;
		end
	end

	// receiver stall in random bursts
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enabled && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		row_t   rows[$];
		reply_t typed_rep;
		reply_t want;
		int     n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		{opcode, request_type, request_code, request_value, request_index,
			request_length, endpoint_halted, external_length} = '0;
		mismatches = 0;
		idle_cycles = 0;
		idle_enabled = 1'b0;
		timed_out = 1'b0;
		shadow_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows; typed replies where they can be read off directly
		typed_rep = '0;
		rows.push_back('{mk_event(usbep0_pkg::OP_WAKEUP, '0, '0, '0, '0, '0, 1'b0, '0),
			typed_rep, 1'b1});
		typed_rep = '0; typed_rep.flush = usbep0_pkg::FL_BOTH; typed_rep.cev = usbep0_pkg::CE_RESET;
		rows.push_back('{mk_event(usbep0_pkg::OP_RESET, '1, '1, '1, '1, '1, 1'b1, '1),
			typed_rep, 1'b1});
		typed_rep = '0; typed_rep.action = usbep0_pkg::ACT_SEND; typed_rep.xfer_len = 16'd18;
		typed_rep.source = usbep0_pkg::SRC_DEV;
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h80, usbep0_pkg::REQ_GET_DESC,
			16'h0100, '0, 16'hffff, 1'b0, '0), typed_rep, 1'b1});
		rows.push_back('{mk_event(usbep0_pkg::OP_TX_DONE, '0, '0, '0, '0, '0, 1'b0, '0),
			typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_TX_DONE, '0, '0, '0, '0, '0, 1'b0, '0),
			typed_rep, 1'b0});
		typed_rep = '0; typed_rep.action = usbep0_pkg::ACT_STALL;
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h80, 8'hff, '0, '0, 16'd8, 1'b0, '0),
			typed_rep, 1'b1});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h00, usbep0_pkg::REQ_SET_ADDRESS,
			16'hff7f, '0, '0, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h00, usbep0_pkg::REQ_SET_CONFIG,
			16'h01ff, '0, '0, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h80, usbep0_pkg::REQ_GET_CONFIG,
			'0, '0, 16'd1, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h01, usbep0_pkg::REQ_SET_IFACE,
			16'hffff, 16'hffff, '0, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h81, usbep0_pkg::REQ_GET_IFACE,
			'0, '0, 16'd4, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h82, usbep0_pkg::REQ_GET_STATUS,
			'0, 16'h0081, 16'd2, 1'b1, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h02, usbep0_pkg::REQ_SET_FEATURE,
			'0, 16'h00ff, '0, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h02, usbep0_pkg::REQ_CLEAR_FEATURE,
			16'd1, 16'h0081, '0, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'hA1, 8'h01, '0, '0, 16'd128, 1'b0,
			17'd64), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h80, usbep0_pkg::REQ_GET_DESC,
			16'h0300, '0, 16'd10, 1'b0, '1), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h21, 8'h09, '0, '0, 16'd16, 1'b0, '0),
			typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_RX_DONE, '0, '0, '0, '0, '0, 1'b0, 17'd16),
			typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'h41, 8'h02, '0, '0, 16'd8, 1'b1, '1),
			typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_RX_DONE, '0, '0, '0, '0, '0, 1'b0, '1),
			typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SUSPEND, '0, '0, '0, '0, '0, 1'b0, '0),
			typed_rep, 1'b0});
		rows.push_back('{mk_event(3'd6, '0, '0, '0, '0, '0, 1'b0, '0), typed_rep, 1'b0});
		rows.push_back('{mk_event(3'd7, '1, '1, '1, '1, '1, 1'b1, '1), typed_rep, 1'b0});
		rows.push_back('{mk_event(usbep0_pkg::OP_SETUP, 8'hE0, 8'h00, '0, '0, '0, 1'b0, '0),
			typed_rep, 1'b0});
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				// check the typed reply against the predictor's reply once the event is accepted
				want = rows[i].rep;
				send_event(rows[i].ev);
				if (pending_replies.size() != 0) begin
					want.dstate = pending_replies[$].dstate;
					if (pending_replies[$] !== want) begin
						mismatches++;
						if (mismatches <= 10) $display("row %0d: expected %h predicted %h",
							i, want, pending_replies[$]);
					end
				end
			end else send_event(rows[i].ev);
		end
		drain();

		// random phases under several register settings, extremes included
		idle_enabled = 1'b1;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_register(usbep0_pkg::CFG_DEV_LEN, 16'd0);
					write_register(usbep0_pkg::CFG_CFG_LEN, 16'hffff);
				end
				1: begin
					write_register(usbep0_pkg::CFG_DEV_LEN, 16'd255);
					write_register(usbep0_pkg::CFG_CFG_LEN, 16'd0);
				end
				2: begin
					write_register(usbep0_pkg::CFG_DEV_LEN, 16'd64);
					write_register(usbep0_pkg::CFG_CFG_LEN, 16'd128);
				end
				default: begin
					write_register(usbep0_pkg::CFG_DEV_LEN, 16'($urandom_range(0, 255)));
					write_register(usbep0_pkg::CFG_CFG_LEN, 16'($urandom_range(0, 300)));
				end
			endcase
			// hold off idling in the closing phase
			if (phase == 4) idle_enabled = 1'b0;
			n = 110;
			repeat (n) send_event(random_event());
			drain();
		end

		if (mismatches == 0) $display("usb_control_endpoint_engine: match");
		else $display("usb_control_endpoint_engine: mismatch");
		$finish;
	end

endmodule

[sim.f]
hdl/usbep0_pkg.sv
hdl/usb_control_endpoint_engine.sv
sim/tb_usb_control_endpoint_engine.sv
